// File: rtl/core/bsks_pkg.sv
package bsks_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int KEY_W       = 32;
    localparam int DATA_W      = 8;
    localparam int COUNT_W     = 11;
    localparam int POS_W       = 11;

    typedef enum logic [1:0] {
        FN_PUSH = 2'd0,
        FN_POP  = 2'd1,
        FN_FIND = 2'd2,
        FN_READ = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_RANGE     = 3'd4
    } status_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
    } mem_req_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
    } mem_rsp_t;

endpackage

// File: rtl/core/bsks_if.sv
interface bsks_in_if;
    logic                              valid;
    logic                              ready;
    bsks_pkg::func_t                   func;
    logic [bsks_pkg::KEY_W-1:0]        key_in;
    logic [bsks_pkg::DATA_W-1:0]       data_in;
    logic [bsks_pkg::POS_W-1:0]        position;

    modport source (output valid, output func, output key_in, output data_in,
                    output position, input ready);
    modport sink   (input valid, input func, input key_in, input data_in,
                    input position, output ready);
endinterface

interface bsks_out_if;
    logic                              valid;
    logic                              ready;
    bsks_pkg::status_t                 status;
    logic [bsks_pkg::KEY_W-1:0]        key_out;
    logic [bsks_pkg::DATA_W-1:0]       data_out;
    logic [bsks_pkg::COUNT_W-1:0]      count;

    modport source (output valid, output status, output key_out, output data_out,
                    output count, input ready);
    modport sink   (input valid, input status, input key_out, input data_out,
                    input count, output ready);
endinterface

// File: rtl/core/bsks_cell_ram.sv
module bsks_cell_ram (
    input  logic               clk,
    input  bsks_pkg::mem_req_t req,
    output bsks_pkg::mem_rsp_t rsp
);
    import bsks_pkg::*;

    logic [KEY_W-1:0]  key_mem  [STACK_DEPTH];
    logic [DATA_W-1:0] data_mem [STACK_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                key_mem[req.addr]  <= req.key;
                data_mem[req.addr] <= req.data;
            end
            else
            begin
                rsp.key  <= key_mem[req.addr];
                rsp.data <= data_mem[req.addr];
            end
        end
    end

endmodule

// File: rtl/core/bsks_ctrl.sv
module bsks_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    bsks_in_if.sink            in_ch,
    bsks_out_if.source         out_ch,
    output bsks_pkg::mem_req_t req,
    input  bsks_pkg::mem_rsp_t rsp
);
    import bsks_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WAIT = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic [COUNT_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [KEY_W-1:0]   find_key_reg, find_key_next;
    status_t            res_status_reg, res_status_next;
    logic [KEY_W-1:0]   res_key_reg, res_key_next;
    logic [DATA_W-1:0]  res_data_reg, res_data_next;
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg;
    logic [KEY_W-1:0]   out_key_reg;
    logic [DATA_W-1:0]  out_data_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic               accept;
    logic               is_full;
    logic               is_empty;
    logic               pos_bad;
    logic               hit;
    logic               last;
    logic               issue;
    logic               out_load;
    logic [COUNT_W-1:0] count_dec;
    logic [POS_W-1:0]   pos_dec;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign is_full     = (count_reg == COUNT_W'(STACK_DEPTH));
    assign is_empty    = (count_reg == '0);
    assign pos_bad     = (in_ch.position == '0) || (in_ch.position > POS_W'(count_reg));
    assign count_dec   = count_reg - COUNT_W'(1);
    assign pos_dec     = in_ch.position - POS_W'(1);
    assign hit         = cmp_valid_reg && (rsp.key == find_key_reg);
    assign last        = cmp_valid_reg && (cmp_idx_reg == count_dec);
    assign issue       = (state_reg == S_SCAN) && (scan_idx_reg < count_reg) && !hit;
    assign out_load    = (state_reg == S_DONE) && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_valid_next  = 1'b0;
        find_key_next   = find_key_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_data_next   = res_data_reg;
        req             = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = ST_OK;
                    res_key_next    = '0;
                    res_data_next   = '0;
                    unique case (in_ch.func)
                        FN_PUSH:
                        begin
                            state_next = S_DONE;
                            if (is_full)
                                res_status_next = ST_FULL;
                            else
                            begin
                                req.en     = 1'b1;
                                req.we     = 1'b1;
                                req.addr   = count_reg[ADDR_W-1:0];
                                req.key    = in_ch.key_in;
                                req.data   = in_ch.data_in;
                                count_next = count_reg + COUNT_W'(1);
                            end
                        end
                        FN_POP:
                        begin
                            if (is_empty)
                            begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                req.en     = 1'b1;
                                req.addr   = count_dec[ADDR_W-1:0];
                                count_next = count_dec;
                                state_next = S_WAIT;
                            end
                        end
                        FN_FIND:
                        begin
                            find_key_next = in_ch.key_in;
                            scan_idx_next = '0;
                            if (is_empty)
                            begin
                                res_status_next = ST_NOT_FOUND;
                                state_next      = S_DONE;
                            end
                            else
                                state_next = S_SCAN;
                        end
                        FN_READ:
                        begin
                            if (pos_bad)
                            begin
                                res_status_next = ST_RANGE;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                req.en     = 1'b1;
                                req.addr   = pos_dec[ADDR_W-1:0];
                                state_next = S_WAIT;
                            end
                        end
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_WAIT:
            begin
                res_key_next  = rsp.key;
                res_data_next = rsp.data;
                state_next    = S_DONE;
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    req.en         = 1'b1;
                    req.addr       = scan_idx_reg[ADDR_W-1:0];
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_idx_reg;
                    scan_idx_next  = scan_idx_reg + COUNT_W'(1);
                end
                if (hit)
                begin
                    res_key_next  = rsp.key;
                    res_data_next = rsp.data;
                    state_next    = S_DONE;
                end
                else if (last)
                begin
                    res_status_next = ST_NOT_FOUND;
                    state_next      = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg   <= scan_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        find_key_reg   <= find_key_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_data_reg   <= res_data_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_key_reg    <= res_key_reg;
            out_data_reg   <= res_data_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.status   = out_status_reg;
    assign out_ch.key_out  = out_key_reg;
    assign out_ch.data_out = out_data_reg;
    assign out_ch.count    = out_count_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(STACK_DEPTH))
        else $error("fill count above stack depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.func == FN_PUSH && !is_full)
        |=> count_reg == $past(count_reg) + COUNT_W'(1))
        else $error("push did not grow the stack");

    a_write_on_push: assert property (@(posedge clk) disable iff (!rst_n)
        (req.en && req.we) |-> (accept && in_ch.func == FN_PUSH))
        else $error("cell write outside a push");

    a_no_cell_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.status != ST_OK) |-> (out_ch.key_out == '0))
        else $error("failed item returned a key");
`endif

endmodule

// File: rtl/core/bounded_stack_with_key_search.sv
// bounded stack of key/data cells with a linear key search
// in_ch carries one operation per item: push, pop, find by key or read by
// 1-based position; out_ch returns exactly one result item per operation
// with a status, the returned cell (zero when none) and the fill count
// after the operation. both channels use valid/ready handshakes.
// the cells live in a single-port synchronous ram with a registered read port
// steps from input accept to output valid:
//   push, or any failing op found without a cell read: done, output register
//   pop and read: one ram read, wait state, done, output register
//   find: scan state, then done and output register; the scan reads one cell
//   per cycle from the bottom and stops at the first match or the last cell
// one operation is in flight at a time; the next item is taken as soon as
// the result moves into the output register, even while that result still
// waits for the receiver. a stalled receiver holds the result and, once the
// following result is done, stalls the input.
// reset empties the stack at once; cell contents are not cleared
module bounded_stack_with_key_search (
    input  logic       clk,
    input  logic       rst_n,
    bsks_in_if.sink    in_ch,
    bsks_out_if.source out_ch
);
    import bsks_pkg::*;

    mem_req_t req;
    mem_rsp_t rsp;

    bsks_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .req    (req),
        .rsp    (rsp)
    );

    bsks_cell_ram u_ram (
        .clk (clk),
        .req (req),
        .rsp (rsp)
    );

endmodule
